// File: rtl/talm_pkg.sv
// ============================================================================
// talm_pkg
// Shared types and codes for the temperature alarm state machine.
// ============================================================================
`default_nettype none

package talm_pkg;

    localparam int TEMP_W  = 12;
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Machine phases, encoded as they appear on the phase port
    typedef enum logic [PHASE_W-1:0] {
        PH_NORMAL    = 3'd0,
        PH_CHK_PRE   = 3'd1,
        PH_PRE       = 3'd2,
        PH_CHK_ALARM = 3'd3,
        PH_ALARM     = 3'd4
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_TH      = 3'd0,
        CFG_ALARM_TH    = 3'd1,
        CFG_PRE_CONFIRM = 3'd2,
        CFG_ALM_CONFIRM = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] pre_th;
        logic signed [TEMP_W-1:0] alarm_th;
        logic [TIME_W-1:0]        pre_confirm;
        logic [TIME_W-1:0]        alarm_confirm;
    } talm_cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] entry_time;
        logic              just_entered;
        logic              pre_flag;
        logic              alarm_flag;
        logic              alarm_lamp;
        logic              normal_lamp;
    } talm_state_t;

    localparam logic signed [TEMP_W-1:0] PRE_TH_RST      = 12'sd400;
    localparam logic signed [TEMP_W-1:0] ALARM_TH_RST    = 12'sd480;
    localparam logic [TIME_W-1:0]        PRE_CONFIRM_RST = 32'd3000;
    localparam logic [TIME_W-1:0]        ALM_CONFIRM_RST = 32'd5000;

endpackage

`default_nettype wire

// File: rtl/temperature_alarm_fsm.sv
// ============================================================================
// temperature_alarm_fsm
// Temperature alarm machine: one sample tick in, one status word out.
// ============================================================================
// Each accepted input word is one sensor tick (temperature in 1/16 degree,
// button level, millisecond timestamp). The block answers every tick with one
// output word carrying the flags, lamp drives and phase after that tick. It
// takes a new word every cycle while the output is not stalled; a word goes
// through the input register, then the machine state register, which is
// also the output register. The update loop runs from the state register
// through the threshold compares and the elapsed-time subtract back into
// the state register. Thresholds and confirm times are written through the
// configuration port, which is always ready; write it only while no tick is
// in flight. Indexes 4 and up are ignored.
// ============================================================================
`default_nettype none

module temperature_alarm_fsm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [talm_pkg::TEMP_W-1:0]    temperature,
    input  logic                                  button_pressed,
    input  logic [talm_pkg::TIME_W-1:0]           now_ms,
    // status channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  pre_warn,
    output logic                                  alarm,
    output logic                                  alarm_lamp,
    output logic                                  normal_lamp,
    output logic [talm_pkg::PHASE_W-1:0]          phase,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [talm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [talm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import talm_pkg::*;

    // Configuration registers
    talm_cfg_t cfg_reg;

    // Input register stage
    logic                     s1_valid_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s1_button_reg;
    logic [TIME_W-1:0]        s1_now_reg;

    // Machine state, doubles as the output register
    talm_state_t state_reg;
    talm_state_t state_next;
    logic        out_valid_reg;

    logic in_take;
    logic advance;

    // Advance the held tick when the output slot is free or being drained
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_th        <= PRE_TH_RST;
            cfg_reg.alarm_th      <= ALARM_TH_RST;
            cfg_reg.pre_confirm   <= PRE_CONFIRM_RST;
            cfg_reg.alarm_confirm <= ALM_CONFIRM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRE_TH:      cfg_reg.pre_th        <= cfg_data[TEMP_W-1:0];
                CFG_ALARM_TH:    cfg_reg.alarm_th      <= cfg_data[TEMP_W-1:0];
                CFG_PRE_CONFIRM: cfg_reg.pre_confirm   <= cfg_data[TIME_W-1:0];
                CFG_ALM_CONFIRM: cfg_reg.alarm_confirm <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register: hold the tick until the machine takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_temp_reg   <= temperature;
            s1_button_reg <= button_pressed;
            s1_now_reg    <= now_ms;
        end
    end

    talm_step u_step (
        .cur            (state_reg),
        .cfg            (cfg_reg),
        .temperature    (s1_temp_reg),
        .button_pressed (s1_button_reg),
        .now_ms         (s1_now_reg),
        .nxt            (state_next)
    );

    // State update and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_NORMAL;
            state_reg.entry_time   <= '0;
            state_reg.just_entered <= 1'b1;
            state_reg.pre_flag     <= 1'b0;
            state_reg.alarm_flag   <= 1'b0;
            state_reg.alarm_lamp   <= 1'b0;
            state_reg.normal_lamp  <= 1'b1;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pre_warn    = state_reg.pre_flag;
    assign alarm       = state_reg.alarm_flag;
    assign alarm_lamp  = state_reg.alarm_lamp;
    assign normal_lamp = state_reg.normal_lamp;
    assign phase       = state_reg.phase;

    // Lamps are always driven as a complementary pair
    a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_lamp != normal_lamp)
        else $error("alarm and normal lamps not complementary");

    // The alarm flag only stands while the machine sits in alarm
    a_alarm_flag_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.alarm_flag |-> (state_reg.phase == PH_ALARM))
        else $error("alarm flag set outside alarm phase");

    // Machine state moves only when a tick is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a processed tick");

    // A processed tick always produces an output word
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed tick produced no output");

    // Back-pressure on the input only while a tick is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with free pipeline");

endmodule

`default_nettype wire

// File: rtl/talm_step.sv
// ============================================================================
// talm_step
// Next-state logic of the alarm machine for one tick.
// ============================================================================
`default_nettype none

module talm_step (
    input  talm_pkg::talm_state_t                  cur,
    input  talm_pkg::talm_cfg_t                    cfg,
    input  logic signed [talm_pkg::TEMP_W-1:0]     temperature,
    input  logic                                   button_pressed,
    input  logic [talm_pkg::TIME_W-1:0]            now_ms,
    output talm_pkg::talm_state_t                  nxt
);
    import talm_pkg::*;

    logic              ge_alarm;
    logic              ge_pre;
    logic [TIME_W-1:0] elapsed;
    logic              pre_done;
    logic              alarm_done;

    assign ge_alarm   = (temperature >= cfg.alarm_th);
    assign ge_pre     = (temperature >= cfg.pre_th);
    assign elapsed    = now_ms - cur.entry_time;
    assign pre_done   = (elapsed > cfg.pre_confirm);
    assign alarm_done = (elapsed > cfg.alarm_confirm);

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_NORMAL:
            begin
                if (cur.just_entered)
                begin
                    nxt.pre_flag     = 1'b0;
                    nxt.alarm_flag   = 1'b0;
                    nxt.just_entered = 1'b0;
                end
                // pre threshold test comes first and wins
                if (ge_pre)
                begin
                    nxt.phase        = PH_CHK_PRE;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
                else if (ge_alarm)
                begin
                    nxt.phase        = PH_CHK_ALARM;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
            end
            PH_CHK_PRE:
            begin
                // a move to alarm checking restarts the timer, so the
                // confirm test then counts elapsed time from that move
                if (!ge_pre)
                begin
                    nxt.phase        = PH_NORMAL;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
                else if (!ge_alarm && pre_done)
                begin
                    nxt.phase        = PH_PRE;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
                else if (ge_alarm)
                begin
                    nxt.phase        = PH_CHK_ALARM;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
            end
            PH_PRE:
            begin
                if (cur.just_entered)
                begin
                    nxt.pre_flag     = 1'b1;
                    nxt.just_entered = 1'b0;
                end
                if (!ge_pre)
                begin
                    nxt.phase        = PH_NORMAL;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
                else if (ge_alarm)
                begin
                    nxt.phase        = PH_CHK_ALARM;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
            end
            PH_CHK_ALARM:
            begin
                if (!ge_alarm)
                begin
                    nxt.phase        = PH_PRE;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
                else if (alarm_done)
                begin
                    nxt.phase        = PH_ALARM;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
            end
            PH_ALARM:
            begin
                if (cur.just_entered)
                begin
                    nxt.pre_flag     = 1'b0;
                    nxt.alarm_flag   = 1'b1;
                    nxt.alarm_lamp   = 1'b1;
                    nxt.normal_lamp  = 1'b0;
                    nxt.just_entered = 1'b0;
                end
                if (button_pressed)
                begin
                    nxt.alarm_flag   = 1'b0;
                    nxt.alarm_lamp   = 1'b0;
                    nxt.normal_lamp  = 1'b1;
                    nxt.phase        = PH_NORMAL;
                    nxt.entry_time   = now_ms;
                    nxt.just_entered = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire
